@@ hdl/kme_pkg.sv @@
// Shared types and constants for the keyer macro expander.
`default_nettype none
package kme_pkg;

   localparam int CALL_MAX      = 8;
   localparam int CHAR_BITS     = 8;
   localparam int CALL_BITS     = CALL_MAX * CHAR_BITS;
   localparam int LEN_BITS      = 4;
   localparam int IDX_BITS      = 3;
   localparam int DEC_DIGITS    = 5;
   localparam int BCD_BITS      = DEC_DIGITS * 4;
   localparam int BCD_PAD_BITS  = 32;
   localparam int KIND_BITS     = 3;
   localparam int VALUE_BITS    = 16;
   localparam int ACCUM_BITS    = 16;
   localparam int REQ_DATA_BITS = 8;
   localparam int RSP_DATA_BITS = 16;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_ADDR_BITS-1:0] REG_CALL_CHARS = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CALL_LEN   = 1'd1;

   localparam logic [CHAR_BITS-1:0] CH_DOLLAR  = 8'h24;
   localparam logic [CHAR_BITS-1:0] CH_STAR    = 8'h2A;
   localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CHAR_BITS-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [CHAR_BITS-1:0] CH_C       = 8'h43;
   localparam logic [CHAR_BITS-1:0] CH_N       = 8'h4E;
   localparam logic [CHAR_BITS-1:0] CH_P       = 8'h50;
   localparam logic [CHAR_BITS-1:0] CH_R       = 8'h52;
   localparam logic [CHAR_BITS-1:0] CH_S       = 8'h53;
   localparam logic [CHAR_BITS-1:0] CASE_GAP   = 8'h20;

   typedef enum logic [KIND_BITS-1:0] {
      EV_CHAR, EV_SPEED, EV_WAIT, EV_PSTART, EV_PEND
   } event_kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_DOLLAR, MODE_NPEND, MODE_SDIG, MODE_PDIG, MODE_PRO1, MODE_PRO2
   } parse_mode_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_CONV, ST_PRE, ST_TAIL0, ST_TAIL1
   } ctrl_state_type;

   typedef enum logic [1:0] {PRE_NONE, PRE_SINGLE, PRE_CALL, PRE_DEC} pre_type;
   typedef enum logic [1:0] {TAIL_NONE, TAIL_CHAR, TAIL_PSTART} tail_type;
   typedef enum logic [1:0] {SER_HOLD, SER_INC, SER_DEC} serial_op_type;
   typedef enum logic {CONV_SERIAL, CONV_PREV} conv_src_type;
   typedef enum logic [1:0] {ACC_HOLD, ACC_CLEAR, ACC_SHIFT} accum_op_type;
   typedef enum logic [2:0] {
      VAL_ZERO, VAL_ACCUM8, VAL_ACCUM16, VAL_CHAR, VAL_CALL, VAL_DIGIT
   } value_src_type;

   typedef struct packed {
      logic           capture;
      serial_op_type  serial_op;
      logic           conv_start;
      conv_src_type   conv_src;
      accum_op_type   accum_op;
      logic           idx_clear;
      logic           emit;
      event_kind_type kind;
      value_src_type  vsrc;
      logic           run_end;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic is_dollar;
      logic is_star;
      logic is_digit;
      logic is_alpha;
      logic is_plus;
      logic is_minus;
      logic cmd_c;
      logic cmd_n;
      logic cmd_s;
      logic cmd_p;
      logic cmd_r;
      logic digit_seen;
      logic call_empty;
      logic call_last;
      logic conv_done;
      logic dec_last;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

@@ hdl/kme_datapath.sv @@
// Datapath: character capture, serial number, digit accumulator, decimal conversion, output.
`default_nettype none
module kme_datapath #(
   parameter int CALL_LEN    = 8,
   parameter int SERIAL_BITS = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire  [kme_pkg::REQ_DATA_BITS-1:0]       req_tdata,
   input  wire                                     req_tlast,
   output logic                                    rsp_tvalid,
   input  wire                                     rsp_tready,
   output logic [kme_pkg::RSP_DATA_BITS-1:0]       rsp_tdata,
   output logic [kme_pkg::KIND_BITS-1:0]           rsp_tuser,
   output logic                                    rsp_tlast,
   input  wire                                     csr_we,
   input  wire  [kme_pkg::CSR_ADDR_BITS-1:0]       csr_addr,
   input  wire  [kme_pkg::CSR_DATA_BITS-1:0]       csr_wdata,
   input  kme_pkg::dp_cmd_type                     cmd,
   output kme_pkg::dp_status_type                  status
);
   import kme_pkg::*;

   localparam int CNT_BITS = $clog2(SERIAL_BITS + 1);

   logic [CHAR_BITS-1:0]        char_ff, char_in;
   logic                        last_ff, last_in;
   logic [CALL_LEN*8-1:0]       call_ff, call_in;
   logic [LEN_BITS-1:0]         len_ff, len_in;
   logic [SERIAL_BITS-1:0]      serial_ff, serial_in;
   logic [ACCUM_BITS-1:0]       accum_ff, accum_in;
   logic                        seen_ff, seen_in;
   logic [IDX_BITS-1:0]         idx_ff, idx_in;
   logic [SERIAL_BITS-1:0]      bin_ff, bin_in;
   logic [BCD_BITS-1:0]         bcd_ff, bcd_in;
   logic [CNT_BITS-1:0]         cnt_ff, cnt_in;
   logic                        out_valid_ff, out_valid_in;
   logic [KIND_BITS-1:0]        out_kind_ff, out_kind_in;
   logic [VALUE_BITS-1:0]       out_value_ff, out_value_in;
   logic                        out_last_ff, out_last_in;

   logic [CHAR_BITS-1:0]        folded;
   logic                        is_lower;
   logic                        is_upper;
   logic [SERIAL_BITS-1:0]      serial_prev;
   logic [BCD_BITS-1:0]         bcd_adj;
   logic [IDX_BITS-1:0]         ndig;
   logic [IDX_BITS-1:0]         idx_next;
   logic [IDX_BITS-1:0]         dig_pos;
   logic [BCD_PAD_BITS-1:0]     bcd_pad;
   logic [3:0]                  digit;
   logic [CALL_BITS-1:0]        call_pad;
   logic [CHAR_BITS-1:0]        call_byte;
   logic [LEN_BITS-1:0]         call_n;
   logic                        out_free;
   logic                        idx_step;

   assign is_lower = char_ff inside {[CH_LOWER_A:CH_LOWER_Z]};
   assign is_upper = char_ff inside {[CH_UPPER_A:CH_UPPER_Z]};
   assign folded   = is_lower ? char_ff - CASE_GAP : char_ff;

   assign serial_prev = (serial_ff > SERIAL_BITS'(1)) ? serial_ff - SERIAL_BITS'(1)
                                                      : SERIAL_BITS'(1);

   assign call_n    = (len_ff > LEN_BITS'(CALL_LEN)) ? LEN_BITS'(CALL_LEN) : len_ff;
   assign call_pad  = CALL_BITS'(call_ff);
   assign call_byte = call_pad[idx_ff*CHAR_BITS +: CHAR_BITS];
   assign idx_next  = idx_ff + IDX_BITS'(1);

   always_comb begin
      ndig = IDX_BITS'(1);
      for (int i = 1; i < DEC_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] != 4'd0) begin
            ndig = IDX_BITS'(i + 1);
         end
      end
   end

   assign dig_pos = ndig - IDX_BITS'(1) - idx_ff;
   assign bcd_pad = BCD_PAD_BITS'(bcd_ff);
   assign digit   = bcd_pad[dig_pos*4 +: 4];

   always_comb begin
      for (int i = 0; i < DEC_DIGITS; i++) begin
         bcd_adj[i*4 +: 4] = (bcd_ff[i*4 +: 4] >= 4'd5) ? bcd_ff[i*4 +: 4] + 4'd3
                                                      : bcd_ff[i*4 +: 4];
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign idx_step = cmd.emit && (cmd.vsrc == VAL_CALL || cmd.vsrc == VAL_DIGIT);

   always_comb begin
      char_in   = cmd.capture ? req_tdata : char_ff;
      last_in   = cmd.capture ? req_tlast : last_ff;
      call_in   = call_ff;
      len_in    = len_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_CALL_CHARS: call_in = csr_wdata[CALL_LEN*8-1:0];
            REG_CALL_LEN:   len_in  = csr_wdata[LEN_BITS-1:0];
            default:        call_in = call_ff;
         endcase
      end

      serial_in = serial_ff;
      case (cmd.serial_op)
         SER_INC: begin
            if (serial_ff != {SERIAL_BITS{1'b1}}) serial_in = serial_ff + SERIAL_BITS'(1);
         end
         SER_DEC: begin
            if (serial_ff > SERIAL_BITS'(1)) serial_in = serial_ff - SERIAL_BITS'(1);
         end
         default: serial_in = serial_ff;
      endcase

      accum_in = accum_ff;
      seen_in  = seen_ff;
      case (cmd.accum_op)
         ACC_CLEAR: begin
            accum_in = '0;
            seen_in  = 1'b0;
         end
         ACC_SHIFT: begin
            accum_in = (accum_ff << 3) + (accum_ff << 1)
                     + ACCUM_BITS'(char_ff - CH_ZERO);
            seen_in  = 1'b1;
         end
         default: accum_in = accum_ff;
      endcase

      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (idx_step) begin
         idx_in = idx_next;
      end else begin
         idx_in = idx_ff;
      end

      bin_in = bin_ff;
      bcd_in = bcd_ff;
      cnt_in = cnt_ff;
      if (cmd.conv_start) begin
         bin_in = (cmd.conv_src == CONV_PREV) ? serial_prev : serial_ff;
         bcd_in = '0;
         cnt_in = CNT_BITS'(SERIAL_BITS);
      end else if (cnt_ff != '0) begin
         bin_in = bin_ff << 1;
         bcd_in = {bcd_adj[BCD_BITS-2:0], bin_ff[SERIAL_BITS-1]};
         cnt_in = cnt_ff - CNT_BITS'(1);
      end

      out_valid_in = out_valid_ff && !rsp_tready;
      out_kind_in  = out_kind_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_kind_in  = cmd.kind;
         out_last_in  = cmd.run_end;
         case (cmd.vsrc)
            VAL_ACCUM8:  out_value_in = VALUE_BITS'(accum_ff[7:0]);
            VAL_ACCUM16: out_value_in = VALUE_BITS'(accum_ff);
            VAL_CHAR:    out_value_in = VALUE_BITS'(char_ff);
            VAL_CALL:    out_value_in = VALUE_BITS'(call_byte);
            VAL_DIGIT:   out_value_in = VALUE_BITS'(CH_ZERO | CHAR_BITS'(digit));
            default:     out_value_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      last_ff      <= last_in;
      idx_ff       <= idx_in;
      bin_ff       <= bin_in;
      bcd_ff       <= bcd_in;
      out_kind_ff  <= out_kind_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
      if (reset) begin
         call_ff      <= '0;
         len_ff       <= '0;
         serial_ff    <= SERIAL_BITS'(1);
         accum_ff     <= '0;
         seen_ff      <= 1'b0;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         call_ff      <= call_in;
         len_ff       <= len_in;
         serial_ff    <= serial_in;
         accum_ff     <= accum_in;
         seen_ff      <= seen_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      status.last       = last_ff;
      status.is_dollar  = (char_ff == CH_DOLLAR);
      status.is_star    = (char_ff == CH_STAR);
      status.is_digit   = char_ff inside {[CH_ZERO:CH_NINE]};
      status.is_alpha   = is_lower || is_upper;
      status.is_plus    = (char_ff == CH_PLUS);
      status.is_minus   = (char_ff == CH_MINUS);
      status.cmd_c      = (folded == CH_C);
      status.cmd_n      = (folded == CH_N);
      status.cmd_s      = (folded == CH_S);
      status.cmd_p      = (folded == CH_P);
      status.cmd_r      = (folded == CH_R);
      status.digit_seen = seen_ff;
      status.call_empty = (call_n == '0);
      status.call_last  = ({1'b0, idx_ff} + LEN_BITS'(1)) == call_n;
      status.conv_done  = (cnt_ff == '0);
      status.dec_last   = (idx_next == ndig);
      status.out_free   = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_value_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

endmodule
`default_nettype wire

@@ hdl/kme_controller.sv @@
// Controller: parse mode, decode of each character and sequencing of the events it causes.
`default_nettype none
module kme_controller (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_tvalid,
   output logic                    req_tready,
   input  kme_pkg::dp_status_type  status,
   output kme_pkg::dp_cmd_type     cmd
);
   import kme_pkg::*;

   ctrl_state_type state_ff, state_in;
   parse_mode_type mode_ff, mode_in;
   pre_type        pre_ff, pre_in;
   event_kind_type skind_ff, skind_in;
   value_src_type  ssrc_ff, ssrc_in;
   tail_type       tail_ff, tail_in;
   logic           pend_ff, pend_in;

   tail_type       idle_tail;
   logic           idle_pend;
   parse_mode_type idle_mode;
   logic           tail_empty;

   assign tail_empty = (tail_ff == TAIL_NONE);

   always_comb begin
      if (status.is_dollar) begin
         idle_tail = TAIL_NONE;
         idle_pend = 1'b0;
         idle_mode = status.last ? MODE_IDLE : MODE_DOLLAR;
      end else if (status.is_star) begin
         idle_tail = TAIL_PSTART;
         idle_pend = status.last;
         idle_mode = status.last ? MODE_IDLE : MODE_PRO1;
      end else begin
         idle_tail = TAIL_CHAR;
         idle_pend = 1'b0;
         idle_mode = MODE_IDLE;
      end
   end

   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      pre_in     = pre_ff;
      skind_in   = skind_ff;
      ssrc_in    = ssrc_ff;
      tail_in    = tail_ff;
      pend_in    = pend_ff;
      req_tready = 1'b0;
      cmd        = '0;

      case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            cmd.idx_clear = 1'b1;
            pre_in   = PRE_NONE;
            skind_in = EV_PEND;
            ssrc_in  = VAL_ZERO;
            tail_in  = TAIL_NONE;
            pend_in  = 1'b0;
            mode_in  = MODE_IDLE;
            case (mode_ff)
               MODE_DOLLAR: begin
                  if (status.cmd_c) begin
                     pre_in = PRE_CALL;
                  end else if (status.cmd_n) begin
                     if (status.last) begin
                        pre_in         = PRE_DEC;
                        cmd.conv_start = 1'b1;
                        cmd.conv_src   = CONV_SERIAL;
                        cmd.serial_op  = SER_INC;
                     end else begin
                        mode_in = MODE_NPEND;
                     end
                  end else if (status.cmd_s || status.cmd_p) begin
                     cmd.accum_op = ACC_CLEAR;
                     if (!status.last) mode_in = status.cmd_s ? MODE_SDIG : MODE_PDIG;
                  end
               end
               MODE_NPEND: begin
                  if (status.is_plus) begin
                     cmd.serial_op = SER_INC;
                  end else if (status.is_minus) begin
                     cmd.serial_op = SER_DEC;
                  end else if (status.cmd_r) begin
                     pre_in         = PRE_DEC;
                     cmd.conv_start = 1'b1;
                     cmd.conv_src   = CONV_PREV;
                  end else begin
                     pre_in         = PRE_DEC;
                     cmd.conv_start = 1'b1;
                     cmd.conv_src   = CONV_SERIAL;
                     cmd.serial_op  = SER_INC;
                     tail_in        = idle_tail;
                     pend_in        = idle_pend;
                     mode_in        = idle_mode;
                  end
               end
               MODE_SDIG, MODE_PDIG: begin
                  if (status.is_digit) cmd.accum_op = ACC_SHIFT;
                  if (status.is_digit && !status.last) begin
                     mode_in = mode_ff;
                  end else begin
                     if (status.is_digit || status.digit_seen) begin
                        pre_in   = PRE_SINGLE;
                        skind_in = (mode_ff == MODE_SDIG) ? EV_SPEED : EV_WAIT;
                        ssrc_in  = (mode_ff == MODE_SDIG) ? VAL_ACCUM8 : VAL_ACCUM16;
                     end
                     if (!status.is_digit) begin
                        tail_in = idle_tail;
                        pend_in = idle_pend;
                        mode_in = idle_mode;
                     end
                  end
               end
               MODE_PRO1: begin
                  tail_in = TAIL_CHAR;
                  pend_in = status.last;
                  mode_in = status.last ? MODE_IDLE : MODE_PRO2;
               end
               MODE_PRO2: begin
                  if (status.is_alpha) begin
                     tail_in = TAIL_CHAR;
                     pend_in = 1'b1;
                  end else begin
                     pre_in  = PRE_SINGLE;
                     tail_in = idle_tail;
                     pend_in = idle_pend;
                     mode_in = idle_mode;
                  end
               end
               default: begin
                  tail_in = idle_tail;
                  pend_in = idle_pend;
                  mode_in = idle_mode;
               end
            endcase
            state_in = (pre_in == PRE_DEC) ? ST_CONV : ST_PRE;
         end
         ST_CONV: begin
            if (status.conv_done) state_in = ST_PRE;
         end
         ST_PRE: begin
            case (pre_ff)
               PRE_SINGLE: begin
                  if (status.out_free) begin
                     cmd.emit    = 1'b1;
                     cmd.kind    = skind_ff;
                     cmd.vsrc    = ssrc_ff;
                     cmd.run_end = tail_empty;
                     state_in    = ST_TAIL0;
                  end
               end
               PRE_CALL: begin
                  if (status.call_empty) begin
                     state_in = ST_TAIL0;
                  end else if (status.out_free) begin
                     cmd.emit    = 1'b1;
                     cmd.kind    = EV_CHAR;
                     cmd.vsrc    = VAL_CALL;
                     cmd.run_end = status.call_last && tail_empty;
                     if (status.call_last) state_in = ST_TAIL0;
                  end
               end
               PRE_DEC: begin
                  if (status.out_free) begin
                     cmd.emit    = 1'b1;
                     cmd.kind    = EV_CHAR;
                     cmd.vsrc    = VAL_DIGIT;
                     cmd.run_end = status.dec_last && tail_empty;
                     if (status.dec_last) state_in = ST_TAIL0;
                  end
               end
               default: state_in = ST_TAIL0;
            endcase
         end
         ST_TAIL0: begin
            if (tail_empty) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = (tail_ff == TAIL_CHAR) ? EV_CHAR : EV_PSTART;
               cmd.vsrc    = (tail_ff == TAIL_CHAR) ? VAL_CHAR : VAL_ZERO;
               cmd.run_end = !pend_ff;
               state_in    = pend_ff ? ST_TAIL1 : ST_IDLE;
            end
         end
         ST_TAIL1: begin
            if (status.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = EV_PEND;
               cmd.vsrc    = VAL_ZERO;
               cmd.run_end = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      pre_ff   <= pre_in;
      skind_ff <= skind_in;
      ssrc_ff  <= ssrc_in;
      tail_ff  <= tail_in;
      pend_ff  <= pend_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_IDLE;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/keyer_macro_expander_unit.sv @@
// Keyer macro expander top level: controller and datapath.
// A transfer is accepted when idle and decoded in the next cycle; a prefix and a tail stage follow.
// Each stage sends its events one per cycle while the receiver accepts them; receiver stalls
// hold any stage that is sending, and a prosign end event follows the tail when one is pending.
// $N and $NR first run a shift-and-add-3 conversion of the serial number to BCD.
// Synchronous reset clears the callsign registers, parse mode, state and output valid and sets the serial to 1.
`default_nettype none
module keyer_macro_expander_unit #(
   parameter int CALL_LEN    = 8,
   parameter int SERIAL_BITS = 16
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   input  wire  [kme_pkg::REQ_DATA_BITS-1:0]  req_tdata,   // char_code
   input  wire                                req_tlast,   // last_char
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   output logic [kme_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,   // event_value
   output logic [kme_pkg::KIND_BITS-1:0]      rsp_tuser,   // event_kind
   output logic                               rsp_tlast,   // run_end
   input  wire                                csr_we,
   input  wire  [kme_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire  [kme_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import kme_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   kme_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kme_datapath #(
      .CALL_LEN    (CALL_LEN),
      .SERIAL_BITS (SERIAL_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status)
   );

endmodule
`default_nettype wire
